// File: rtl/core/shc_pkg.sv
// shared types, constants and helpers for the shifted halton coordinate block
package shc_pkg;

  localparam int unsigned MAX_DIMENSIONS_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF     = 32;
  localparam int unsigned DIM_CODES          = 16;
  localparam int unsigned DIG_W              = 9;
  localparam int unsigned FP                 = 49;
  localparam int unsigned FC_W               = 81;
  localparam logic [63:0] DEN_CAP            = 64'h0000_0100_0000_0000;

  localparam logic [8:0] PRIMES [64] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  typedef struct packed {
    logic        [31:0] point_idx;
    logic        [3:0]  dimension;
    logic        [31:0] shift;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } shc_in_t;

  typedef struct packed {
    logic signed [31:0] scaled_value;
    logic        [31:0] fraction;
  } shc_out_t;

  typedef struct packed {
    logic        [3:0]  dimension;
    logic        [31:0] shift;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } shc_ctx_t;

  // base^k saturated at the denominator cap
  function automatic logic [63:0] pow_cap(input logic [63:0] b, input int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < k; i++) begin
      if (p < DEN_CAP) begin
        p = p * b;
      end
      if (p > DEN_CAP) begin
        p = DEN_CAP;
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/shifted_halton_coordinate_top.sv
// top level of the shifted halton coordinate generator
// One request enters per clock and one result leaves per clock when the output side keeps
// up. The pipeline is a chain of INDEX_BITS digit stages, each three registers deep
// (reciprocal multiply, digit extract, digit term), followed by three stages for rotation
// add, range multiply and rounding. A stalled output holds the whole pipeline; nothing is
// dropped or repeated.
module shifted_halton_coordinate_top #(
  parameter int unsigned MAX_DIMENSIONS = shc_pkg::MAX_DIMENSIONS_DEF,
  parameter int unsigned INDEX_BITS     = shc_pkg::INDEX_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  shc_pkg::shc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output shc_pkg::shc_out_t out_data_o
);

  logic                  adv;
  logic [INDEX_BITS:0]   v_s;
  logic [INDEX_BITS-1:0] idx_s  [INDEX_BITS+1];
  logic [31:0]           acc_s  [INDEX_BITS+1];
  logic [31:0]           term_s [INDEX_BITS+1];
  shc_pkg::shc_ctx_t     ctx_s  [INDEX_BITS+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign v_s[0]    = in_valid_i;
  assign idx_s[0]  = INDEX_BITS'(in_data_i.point_idx);
  assign acc_s[0]  = 32'd0;
  assign term_s[0] = 32'd0;
  assign ctx_s[0]  = '{dimension:  in_data_i.dimension,
                       shift:      in_data_i.shift,
                       range_low:  in_data_i.range_low,
                       range_high: in_data_i.range_high};

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_digit
    shc_digit_stage #(
      .INDEX_BITS    (INDEX_BITS),
      .MAX_DIMENSIONS(MAX_DIMENSIONS),
      .DIGIT_POS     (k + 1)
    ) u_digit (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(v_s[k]),
      .idx_i  (idx_s[k]),
      .acc_i  (acc_s[k]),
      .term_i (term_s[k]),
      .ctx_i  (ctx_s[k]),
      .valid_o(v_s[k+1]),
      .idx_o  (idx_s[k+1]),
      .acc_o  (acc_s[k+1]),
      .term_o (term_s[k+1]),
      .ctx_o  (ctx_s[k+1])
    );
  end

  shc_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v_s[INDEX_BITS]),
    .acc_i  (acc_s[INDEX_BITS]),
    .term_i (term_s[INDEX_BITS]),
    .ctx_i  (ctx_s[INDEX_BITS]),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

endmodule

// File: rtl/core/shc_digit_stage.sv
// one radical-inverse digit: reciprocal divide, digit extract, scaled digit term
module shc_digit_stage #(
  parameter int unsigned INDEX_BITS     = shc_pkg::INDEX_BITS_DEF,
  parameter int unsigned MAX_DIMENSIONS = shc_pkg::MAX_DIMENSIONS_DEF,
  parameter int unsigned DIGIT_POS      = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [INDEX_BITS-1:0] idx_i,
  input  logic [31:0]           acc_i,
  input  logic [31:0]           term_i,
  input  shc_pkg::shc_ctx_t     ctx_i,
  output logic                  valid_o,
  output logic [INDEX_BITS-1:0] idx_o,
  output logic [31:0]           acc_o,
  output logic [31:0]           term_o,
  output shc_pkg::shc_ctx_t     ctx_o
);

  localparam int unsigned P  = INDEX_BITS + shc_pkg::DIG_W;
  localparam int unsigned H  = P / 2;
  localparam int unsigned PW = INDEX_BITS + P;
  localparam int unsigned DW = P + shc_pkg::DIG_W;
  localparam int unsigned FW = shc_pkg::FC_W + shc_pkg::DIG_W;

  logic [P-1:0]                 m_tab  [shc_pkg::DIM_CODES];
  logic [shc_pkg::DIG_W-1:0]    b_tab  [shc_pkg::DIM_CODES];
  logic [shc_pkg::FC_W-1:0]     fc_tab [shc_pkg::DIM_CODES];

  for (genvar c = 0; c < shc_pkg::DIM_CODES; c++) begin : g_tab
    localparam logic [8:0]   B   = shc_pkg::PRIMES[c % MAX_DIMENSIONS];
    localparam logic [127:0] MV  = ((128'd1 << P) + 128'(B) - 128'd1) / 128'(B);
    localparam logic [63:0]  POW = shc_pkg::pow_cap(64'(B), DIGIT_POS);
    localparam logic [127:0] FCV = (POW < shc_pkg::DEN_CAP) ?
        (((128'd1 << (shc_pkg::FP + 32)) + 128'(POW) - 128'd1) / 128'(POW)) : 128'd0;
    assign m_tab[c]  = MV[P-1:0];
    assign b_tab[c]  = B;
    assign fc_tab[c] = FCV[shc_pkg::FC_W-1:0];
  end

  // stage a: partial products of index times reciprocal
  logic [P-1:0]            m_sel;
  logic [INDEX_BITS+H-1:0] pl_q;
  logic [PW-H-1:0]         ph_q;
  logic [31:0]             acc_a_q;
  shc_pkg::shc_ctx_t       ctx_a_q;
  logic                    valid_a_q;

  assign m_sel = m_tab[ctx_i.dimension];

  // stage b: quotient and digit
  logic [PW-1:0]             prod;
  logic [DW-1:0]             dprod;
  logic [shc_pkg::DIG_W-1:0] b_a;
  logic [INDEX_BITS-1:0]     q_b_q;
  logic [shc_pkg::DIG_W-1:0] dig_b_q;
  logic [shc_pkg::DIG_W-1:0] b_b_q;
  logic [31:0]               acc_b_q;
  shc_pkg::shc_ctx_t         ctx_b_q;
  logic                      valid_b_q;

  assign prod  = PW'(pl_q) + (PW'(ph_q) << H);
  assign b_a   = b_tab[ctx_a_q.dimension];
  assign dprod = DW'(prod[P-1:0]) * DW'(b_a);

  // stage c: digit term
  logic [FW-1:0]         fprod;
  logic [INDEX_BITS-1:0] idx_c_q;
  logic [31:0]           acc_c_q;
  logic [31:0]           term_c_q;
  shc_pkg::shc_ctx_t     ctx_c_q;
  logic                  valid_c_q;

  assign fprod = FW'(dig_b_q) * FW'(fc_tab[ctx_b_q.dimension]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q     <= (INDEX_BITS + H)'(idx_i) * (INDEX_BITS + H)'(m_sel[H-1:0]);
      ph_q     <= (PW - H)'(idx_i) * (PW - H)'(m_sel[P-1:H]);
      acc_a_q  <= acc_i + term_i;
      ctx_a_q  <= ctx_i;
      q_b_q    <= prod[PW-1:P];
      dig_b_q  <= dprod[DW-1:P];
      b_b_q    <= b_a;
      acc_b_q  <= acc_a_q;
      ctx_b_q  <= ctx_a_q;
      idx_c_q  <= q_b_q;
      acc_c_q  <= acc_b_q;
      term_c_q <= fprod[shc_pkg::FP+31:shc_pkg::FP];
      ctx_c_q  <= ctx_b_q;
    end
  end

  assign valid_o = valid_c_q;
  assign idx_o   = idx_c_q;
  assign acc_o   = acc_c_q;
  assign term_o  = term_c_q;
  assign ctx_o   = ctx_c_q;

  a_digit_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q |-> (dig_b_q < b_b_q))
    else $error("digit not below base");

endmodule

// File: rtl/core/shc_scale.sv
// rotation add and linear mapping of the fraction into the requested range
module shc_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       acc_i,
  input  logic [31:0]       term_i,
  input  shc_pkg::shc_ctx_t ctx_i,
  output logic              valid_o,
  output shc_pkg::shc_out_t data_o
);

  logic signed [32:0] diff;
  logic        [32:0] ndiff;
  logic        [31:0] frac0_q;
  logic        [31:0] mag0_q;
  logic               neg0_q;
  logic signed [31:0] lo0_q;
  logic signed [31:0] hi0_q;
  logic               v0_q;

  assign diff  = {ctx_i.range_high[31], ctx_i.range_high} - {ctx_i.range_low[31], ctx_i.range_low};
  assign ndiff = -diff;

  logic        [63:0] t1_q;
  logic               neg1_q;
  logic signed [31:0] lo1_q;
  logic signed [31:0] hi1_q;
  logic        [31:0] frac1_q;
  logic               v1_q;

  logic [32:0] q2;
  logic [33:0] res2;
  assign q2   = {1'b0, t1_q[63:32]} + 33'(neg1_q && (t1_q[31:0] != 32'd0));
  assign res2 = neg1_q ? ({{2{lo1_q[31]}}, lo1_q} - {1'b0, q2})
                       : ({{2{lo1_q[31]}}, lo1_q} + {1'b0, q2});

  shc_pkg::shc_out_t  out_q;
  logic signed [31:0] lo2_q;
  logic signed [31:0] hi2_q;
  logic               v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac0_q            <= acc_i + term_i + ctx_i.shift;
      neg0_q             <= diff[32];
      mag0_q             <= diff[32] ? ndiff[31:0] : diff[31:0];
      lo0_q              <= ctx_i.range_low;
      hi0_q              <= ctx_i.range_high;
      t1_q               <= 64'(mag0_q) * 64'(frac0_q);
      neg1_q             <= neg0_q;
      lo1_q              <= lo0_q;
      hi1_q              <= hi0_q;
      frac1_q            <= frac0_q;
      out_q.scaled_value <= res2[31:0];
      out_q.fraction     <= frac1_q;
      lo2_q              <= lo1_q;
      hi2_q              <= hi1_q;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = out_q;

  a_within_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((out_q.scaled_value >= lo2_q && out_q.scaled_value <= hi2_q) ||
              (out_q.scaled_value <= lo2_q && out_q.scaled_value >= hi2_q)))
    else $error("scaled value outside range");

  a_zero_frac_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && out_q.fraction == 32'd0) |-> (out_q.scaled_value == lo2_q))
    else $error("zero fraction must give low bound");

endmodule

// File: dv/shifted_halton_coordinate_top_tb.sv
// self-checking testbench for the shifted halton coordinate generator
module shifted_halton_coordinate_top_tb;

  localparam int unsigned LATENCY  = 3 * shc_pkg::INDEX_BITS_DEF + 3;
  localparam int unsigned N_RANDOM = 1600;
  localparam int unsigned N_DIR    = 7;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  shc_pkg::shc_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  shc_pkg::shc_out_t out_data_o;

  shc_pkg::shc_out_t coord_q[$];
  int                err_cnt;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_cycles;

  shc_pkg::shc_in_t  dir_req [N_DIR];
  shc_pkg::shc_out_t dir_exp [N_DIR];
  logic              dir_chk [N_DIR];

  shifted_halton_coordinate_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic shc_pkg::shc_out_t halton_coord(input shc_pkg::shc_in_t req);
    logic [8:0]   bases [16];
    logic [63:0]  idx;
    logic [63:0]  base;
    logic [63:0]  den;
    logic [63:0]  acc;
    logic [63:0]  digit;
    logic [31:0]  frac;
    logic [127:0] prod;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] diff;
    logic signed [63:0] res;
    shc_pkg::shc_out_t o;
    bases = '{9'd2, 9'd3, 9'd5, 9'd7, 9'd11, 9'd13, 9'd17, 9'd19,
              9'd23, 9'd29, 9'd31, 9'd37, 9'd41, 9'd43, 9'd47, 9'd53};
    idx  = {32'd0, req.point_idx};
    base = {55'd0, bases[req.dimension]};
    den  = base;
    acc  = '0;
    while (idx != 0) begin
      digit = idx % base;
      idx   = idx / base;
      if (den < 64'h100_0000_0000) begin
        acc = acc + ((digit << 32) / den);
        den = den * base;
      end
      if (den > 64'h100_0000_0000) den = 64'h100_0000_0000;
    end
    frac = acc[31:0] + req.shift;
    lo   = 64'(req.range_low);
    hi   = 64'(req.range_high);
    diff = hi - lo;
    if (diff >= 0) begin
      prod = 128'(diff) * 128'(frac);
      res  = lo + 64'(prod >> 32);
    end else begin
      mag  = -diff;
      prod = 128'(mag) * 128'(frac);
      q    = 64'(prod >> 32);
      if (prod[31:0] != 0) q = q + 1;
      res  = lo - 64'(q);
    end
    o.scaled_value = res[31:0];
    o.fraction     = frac;
    return o;
  endfunction

  task automatic send_request(input shc_pkg::shc_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    coord_q = {coord_q, halton_coord(req)};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_checked(input shc_pkg::shc_in_t req, input shc_pkg::shc_out_t exp_o);
    if (halton_coord(req) !== exp_o) begin
      $display("%0t table mismatch expected %h actual %h", $time, exp_o, halton_coord(req));
      err_cnt++;
    end
    send_request(req);
  endtask

  function automatic shc_pkg::shc_in_t rand_request();
    shc_pkg::shc_in_t r;
    r.point_idx  = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom;
    r.dimension  = 4'($urandom_range(15));
    r.shift      = $urandom_range(3) == 0 ? 32'd0 : $urandom;
    r.range_low  = $urandom;
    r.range_high = $urandom_range(1) ? $urandom : r.range_low + $urandom_range(65535);
    return r;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (coord_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (coord_q.size() == 0) begin
          $display("%0t unexpected result actual %h", $time, out_data_o);
          err_cnt++;
        end else begin
          if (out_data_o.scaled_value !== coord_q[0].scaled_value) begin
            $display("%0t scaled_value expected %h actual %h", $time,
                     coord_q[0].scaled_value, out_data_o.scaled_value);
            err_cnt++;
          end
          if (out_data_o.fraction !== coord_q[0].fraction) begin
            $display("%0t fraction expected %h actual %h", $time,
                     coord_q[0].fraction, out_data_o.fraction);
            err_cnt++;
          end
          void'(coord_q.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    shc_pkg::shc_in_t  req;
    shc_pkg::shc_out_t exp_o;
    err_cnt       = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;

    // directed rows, expected value typed only where it is plain
    dir_req = '{
      '{32'd1,         4'd0,  32'd0,         32'sh0000_0000, 32'sh0001_0000},
      '{32'd0,         4'd0,  32'd0,         32'sh8000_0000, 32'sh7fff_ffff},
      '{32'd0,         4'd0,  32'hffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000},
      '{32'hffff_ffff, 4'd15, 32'hffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000},
      '{32'hffff_ffff, 4'd0,  32'h0,         32'sh8000_0000, 32'sh7fff_ffff},
      '{32'h8000_0000, 4'd1,  32'h1234_5678, 32'sh0001_0000, 32'shffff_0000},
      '{32'd3,         4'd2,  32'd0,         32'sh0000_1000, 32'sh0000_1000}
    };
    dir_exp = '{
      '{32'sh0000_8000, 32'h8000_0000},
      '{32'sh8000_0000, 32'd0},
      '0, '0, '0, '0, '0
    };
    dir_chk = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // index zero passes the shift through, every dimension
    for (int i = 0; i < 16; i++) begin
      req = '{32'd0, 4'(i), 32'h8000_0000, 32'sh0000_0000, 32'sh0001_0000};
      exp_o = '{32'sh0000_8000, 32'h8000_0000};
      send_checked(req, exp_o);
    end
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_chk[i]) begin
        send_checked(dir_req[i], dir_exp[i]);
      end else begin
        send_request(dir_req[i]);
      end
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 33 : phase == 1 ? 49 : 0;
      recv_idle_pct = phase == 0 ? 49 : phase == 1 ? 33 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        if (n == 100 && phase == 2) hold_cycles = 4 * LATENCY;
        if (n == 300) drain();
        send_request(rand_request());
      end
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0 && coord_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/shc_pkg.sv
rtl/core/shc_digit_stage.sv
rtl/core/shc_scale.sv
rtl/core/shifted_halton_coordinate_top.sv
dv/shifted_halton_coordinate_top_tb.sv
